// ===== sv/srdf_pkg.sv =====
// Shared constants and types for the sparse row dominance filter.
`timescale 1ns / 1ps
package srdf_pkg;
    localparam int MaxRows = 64;
    localparam int MaxCols = 64;
    localparam int RowW    = $clog2(MaxRows);
    localparam int ColW    = $clog2(MaxCols);
    localparam int CntW    = 7;
    localparam int AddrW   = RowW + ColW;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_REDUCE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ROW_FULL = 2'd1;
    localparam logic [1:0] ST_COL_FULL = 2'd2;
    localparam logic [1:0] ST_ORDER    = 2'd3;

    // Datapath commands
    localparam logic [3:0] C_NONE     = 4'd0;
    localparam logic [3:0] C_CAPTURE  = 4'd1;  // latch input word, reset walk pointer
    localparam logic [3:0] C_SRCH     = 4'd2;  // one id table entry
    localparam logic [3:0] C_CLR      = 4'd3;  // clear one matrix cell
    localparam logic [3:0] C_LD_RD    = 4'd4;  // issue cell read for load
    localparam logic [3:0] C_LD_WR    = 4'd5;  // write back saturated sum
    localparam logic [3:0] C_RED_INIT = 4'd6;
    localparam logic [3:0] C_RED_STEP = 4'd7;  // one reduce walk step
    localparam logic [3:0] C_RD_STEP  = 4'd8;  // one read scan step
    localparam logic [3:0] C_RD_INIT  = 4'd9;

    typedef struct packed {
        logic [3:0] cmd;
    } t_ctl;

    typedef struct packed {
        logic srch_done;
        logic clr_done;
        logic red_done;
        logic rd_done;
        logic reduced;
        logic [1:0] load_status;
    } t_sts;
endpackage

// ===== sv/sparse_row_dominance_filter_unit.sv =====
// Top level of the sparse row dominance filter.
// After reset the unit clears its 4096-cell store with busy high; a clear command
// repeats that sweep. A load walks the id tables with registered table reads,
// reduce does each column compare in three phases on the single cell memory port,
// and a read scans the cells, in two phases per cell, until the next nonzero one.
// Each command gives one result word, strobed by o_valid for one cycle; the
// receiver cannot stall.
`timescale 1ns / 1ps
module sparse_row_dominance_filter_unit import srdf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [15:0]        i_row_id,
    input  logic [15:0]        i_col_id,
    input  logic signed [15:0] i_value,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [6:0]         o_kept_rows,
    output logic [6:0]         o_out_row,
    output logic [15:0]        o_out_col_id,
    output logic signed [31:0] o_out_value,
    output logic               o_done_res
);
    t_ctl w_ctl;
    t_sts w_sts;
    logic w_fin;

    srdf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_operation(i_operation), .i_sts(w_sts), .o_ctl(w_ctl),
        .o_busy(busy), .o_fin(w_fin)
    );

    srdf_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_fin(w_fin),
        .i_operation(i_operation), .i_row_id(i_row_id), .i_col_id(i_col_id),
        .i_value(i_value), .o_sts(w_sts), .o_status(o_status),
        .o_kept_rows(o_kept_rows), .o_out_row(o_out_row),
        .o_out_col_id(o_out_col_id), .o_out_value(o_out_value),
        .o_done_res(o_done_res)
    );

    assign o_valid = w_fin;
endmodule

// ===== sv/srdf_ctrl.sv =====
// Sequencer for the filter: picks datapath steps for each command word.
`timescale 1ns / 1ps
module srdf_ctrl import srdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_operation,
    input  t_sts       i_sts,
    output t_ctl       o_ctl,
    output logic       o_busy,
    output logic       o_fin
);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_LDRD = 3'd3;
    localparam logic [2:0] S_LDWR = 3'd4;
    localparam logic [2:0] S_RED  = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] r_st, n_st;
    logic       r_fin, n_fin;

    // Next state and command
    always_comb begin
        n_st  = r_st;
        n_fin = 1'b0;
        o_ctl.cmd = C_NONE;
        case (r_st)
            S_CLR: begin
                o_ctl.cmd = C_CLR;
                if (i_sts.clr_done) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.cmd = C_CAPTURE;
                    case (i_operation)
                        OP_LOAD: n_st = i_sts.reduced ? S_FIN : S_SRCH;
                        OP_REDUCE: n_st = i_sts.reduced ? S_FIN : S_RED;
                        OP_READ: n_st = i_sts.reduced ? S_RD : S_FIN;
                        default: n_st = S_CLR;
                    endcase
                    if (i_operation == OP_CLEAR) n_fin = 1'b1;
                end
            end
            S_SRCH: begin
                o_ctl.cmd = C_SRCH;
                if (i_sts.srch_done) n_st = S_LDRD;
            end
            S_LDRD: begin
                o_ctl.cmd = C_LD_RD;
                if (i_sts.load_status != ST_OK) begin
                    n_st = S_IDLE; n_fin = 1'b1;
                end else n_st = S_LDWR;
            end
            S_LDWR: begin
                o_ctl.cmd = C_LD_WR;
                n_st = S_IDLE; n_fin = 1'b1;
            end
            S_RED: begin
                o_ctl.cmd = C_RED_STEP;
                if (i_sts.red_done) begin
                    n_st = S_IDLE; n_fin = 1'b1;
                end
            end
            S_RD: begin
                o_ctl.cmd = C_RD_STEP;
                if (i_sts.rd_done) begin
                    n_st = S_IDLE; n_fin = 1'b1;
                end
            end
            S_FIN: begin
                n_st = S_IDLE; n_fin = 1'b1;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_fin <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_fin <= n_fin;
        end
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_fin  = r_fin;

    // Result strobe only follows a finished command
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_st == S_IDLE || r_st == S_CLR))
        else $error("result strobe outside idle");
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE && i_start) |=> (r_st != S_IDLE || r_fin))
        else $error("accepted word did not start work");
    a_ldwr_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_LDWR) |=> (r_st == S_IDLE))
        else $error("write back not single cycle");
endmodule

// ===== sv/srdf_dp.sv =====
// Datapath: id tables, cell memory, dominance walk and read scan.
`timescale 1ns / 1ps
module srdf_dp import srdf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic              i_fin,
    input  logic [1:0]        i_operation,
    input  logic [15:0]       i_row_id,
    input  logic [15:0]       i_col_id,
    input  logic signed [15:0] i_value,
    output t_sts              o_sts,
    output logic [1:0]        o_status,
    output logic [CntW-1:0]   o_kept_rows,
    output logic [CntW-1:0]   o_out_row,
    output logic [15:0]       o_out_col_id,
    output logic signed [31:0] o_out_value,
    output logic              o_done_res
);
    // Storage
    logic [15:0]        r_rtab [MaxRows];
    logic [15:0]        r_ctab [MaxCols];
    logic signed [31:0] r_mem  [MaxRows*MaxCols];
    logic signed [31:0] r_rdat;
    logic [MaxRows-1:0] r_rem;

    // Registered id table read data
    logic [15:0]        r_rtd, r_ctd;
    logic [ColW-1:0]    w_caddr;

    logic [CntW-1:0] r_rcnt, r_ccnt, r_kept, r_erow, r_ecol, r_enum;
    logic            r_reduced;
    logic [1:0]      r_op;
    logic [15:0]     r_rid, r_cid;
    logic signed [15:0] r_val;

    // Id search: walk pointer visits both tables together, compare in the next cycle
    logic [CntW-1:0] r_sp;
    logic [CntW-1:0] r_sq;
    logic            r_sv;
    logic            r_rfound, r_cfound;
    logic [RowW-1:0] r_ridx;
    logic [ColW-1:0] r_cidx;
    logic [1:0]      r_lst;

    // Clear sweep
    logic [AddrW:0] r_clr;

    // Reduce walk: phase 0 issue read of a, 1 issue read of b, 2 compare
    logic [CntW-1:0] r_a, r_b, r_c;
    logic [1:0]      r_ph;
    logic signed [31:0] r_va;
    logic            r_le;
    logic            r_rdn;

    // Read scan: phase 0 read issue, 1 evaluate
    logic            r_sph;
    logic            r_sdone, r_shit;
    logic [CntW-1:0] r_orow;
    logic [15:0]     r_ocid;
    logic signed [31:0] r_oval;

    // Memory address/write control
    logic [AddrW-1:0]   w_raddr, w_waddr;
    logic               w_we;
    logic signed [31:0] w_wdat;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_sat;

    logic srch_end;
    assign srch_end = (r_sp >= r_rcnt) && (r_sp >= r_ccnt);

    assign w_sum = 33'(r_rdat) + 33'(r_val);
    always_comb begin
        if (w_sum > 33'sh07FFFFFFF) w_sat = 32'sh7FFFFFFF;
        else if (w_sum < -33'sh080000000) w_sat = 32'sh80000000;
        else w_sat = w_sum[31:0];
    end

    // Read address mux; a load of a new id reads the cell at the next free index
    always_comb begin
        w_raddr = '0;
        case (i_ctl.cmd)
            C_LD_RD: w_raddr = {r_rfound ? r_ridx : r_rcnt[RowW-1:0],
                                r_cfound ? r_cidx : r_ccnt[ColW-1:0]};
            C_RED_STEP: w_raddr = (r_ph == 2'd0) ? {r_a[RowW-1:0], r_c[ColW-1:0]}
                                                 : {r_b[RowW-1:0], r_c[ColW-1:0]};
            C_RD_STEP: w_raddr = {r_erow[RowW-1:0], r_ecol[ColW-1:0]};
            default: w_raddr = '0;
        endcase
    end

    always_comb begin
        w_we = 1'b0; w_waddr = {r_ridx, r_cidx}; w_wdat = w_sat;
        if (i_ctl.cmd == C_CLR) begin
            w_we = !r_clr[AddrW]; w_waddr = r_clr[AddrW-1:0]; w_wdat = '0;
        end else if (i_ctl.cmd == C_LD_WR) w_we = 1'b1;
    end

    // Cell memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdat;
        r_rdat <= r_mem[w_raddr];
    end

    // Main control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt <= '0; r_ccnt <= '0; r_kept <= '0; r_reduced <= 1'b0;
            r_rem <= '0; r_erow <= '0; r_ecol <= '0; r_enum <= '0;
            r_clr <= '0; r_sp <= '0; r_lst <= ST_OK; r_rdn <= 1'b0;
            r_sdone <= 1'b0; r_shit <= 1'b0; r_sph <= 1'b0; r_ph <= '0;
            r_sv <= 1'b0;
        end else begin
            case (i_ctl.cmd)
                C_CAPTURE: begin
                    r_op <= i_operation; r_rid <= i_row_id; r_cid <= i_col_id;
                    r_val <= i_value; r_sp <= '0; r_rfound <= 1'b0;
                    r_cfound <= 1'b0; r_lst <= ST_OK; r_clr <= '0; r_sv <= 1'b0;
                    r_a <= '0; r_b <= '0; r_c <= '0; r_ph <= '0; r_rdn <= 1'b0;
                    r_le <= 1'b1; r_sph <= 1'b0; r_sdone <= 1'b0; r_shit <= 1'b0;
                    if (i_operation == OP_LOAD && r_reduced) r_lst <= ST_ORDER;
                    if (i_operation == OP_REDUCE && r_reduced) r_lst <= ST_ORDER;
                    if (i_operation == OP_READ && !r_reduced) r_lst <= ST_ORDER;
                    if (i_operation == OP_CLEAR) begin
                        r_rcnt <= '0; r_ccnt <= '0; r_kept <= '0; r_reduced <= 1'b0;
                        r_rem <= '0; r_erow <= '0; r_ecol <= '0; r_enum <= '0;
                    end
                end
                C_CLR: r_clr <= r_clr + 1'b1;
                C_SRCH: begin
                    // compare the entries read at the previous pointer
                    if (r_sv) begin
                        if (r_sq < r_rcnt && !r_rfound && r_rtd == r_rid) begin
                            r_rfound <= 1'b1; r_ridx <= r_sq[RowW-1:0];
                        end
                        if (r_sq < r_ccnt && !r_cfound && r_ctd == r_cid) begin
                            r_cfound <= 1'b1; r_cidx <= r_sq[ColW-1:0];
                        end
                    end
                    r_sv <= !srch_end;
                    r_sq <= r_sp;
                    if (!srch_end) r_sp <= r_sp + 1'b1;
                end
                C_LD_RD: begin
                    if (!r_rfound && r_rcnt >= CntW'(MaxRows)) r_lst <= ST_ROW_FULL;
                    else if (!r_cfound && r_ccnt >= CntW'(MaxCols)) r_lst <= ST_COL_FULL;
                    if (!r_rfound) r_ridx <= r_rcnt[RowW-1:0];
                    if (!r_cfound) r_cidx <= r_ccnt[ColW-1:0];
                end
                C_LD_WR: ;
                C_RED_STEP: begin
                    if (r_a >= r_rcnt) begin
                        r_rdn <= 1'b1;
                        r_reduced <= 1'b1;
                    end else if (r_rem[r_a[RowW-1:0]]) begin
                        r_a <= r_a + 1'b1; r_b <= '0;
                    end else if (r_b >= r_rcnt) begin
                        r_a <= r_a + 1'b1; r_b <= '0;
                    end else if (r_b == r_a || r_rem[r_b[RowW-1:0]]) begin
                        r_b <= r_b + 1'b1;
                    end else if (r_c >= r_ccnt) begin
                        if (r_le) begin
                            r_rem[r_b[RowW-1:0]] <= 1'b1;
                            r_kept <= r_kept - 1'b1;
                        end
                        r_b <= r_b + 1'b1; r_c <= '0; r_le <= 1'b1; r_ph <= '0;
                    end else begin
                        case (r_ph)
                            2'd0: r_ph <= 2'd1;
                            2'd1: begin r_va <= r_rdat; r_ph <= 2'd2; end
                            default: begin
                                if (r_va > r_rdat) r_le <= 1'b0;
                                r_c <= r_c + 1'b1; r_ph <= '0;
                            end
                        endcase
                    end
                end
                C_RD_STEP: begin
                    if (r_erow >= r_rcnt) begin
                        r_sdone <= 1'b1;
                    end else if (r_rem[r_erow[RowW-1:0]]) begin
                        r_erow <= r_erow + 1'b1; r_ecol <= '0;
                    end else if (r_ecol >= r_ccnt) begin
                        r_enum <= r_enum + 1'b1; r_erow <= r_erow + 1'b1; r_ecol <= '0;
                    end else if (!r_sph) begin
                        r_sph <= 1'b1;
                    end else begin
                        r_sph <= 1'b0;
                        r_ecol <= r_ecol + 1'b1;
                        if (r_rdat != 0) begin
                            r_sdone <= 1'b1; r_shit <= 1'b1;
                            r_orow <= r_enum + 1'b1;
                            r_ocid <= r_ctd;
                            r_oval <= r_rdat;
                        end
                    end
                end
                default: ;
            endcase
            // Kept count starts at row count when reduce begins
            if (i_ctl.cmd == C_CAPTURE && i_operation == OP_REDUCE && !r_reduced)
                r_kept <= r_rcnt;
            // New ids on successful load
            if (i_ctl.cmd == C_LD_WR) begin
                if (!r_rfound) r_rcnt <= r_rcnt + 1'b1;
                if (!r_cfound) r_ccnt <= r_ccnt + 1'b1;
            end
        end
    end

    // Column table read port: search pointer, or scan column during reads
    assign w_caddr = (i_ctl.cmd == C_RD_STEP) ? r_ecol[ColW-1:0] : r_sp[ColW-1:0];

    // Id tables (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == C_LD_WR) begin
            if (!r_rfound) r_rtab[r_ridx] <= r_rid;
            if (!r_cfound) r_ctab[r_cidx] <= r_cid;
        end
        r_rtd <= r_rtab[r_sp[RowW-1:0]];
        r_ctd <= r_ctab[w_caddr];
    end

    assign o_sts.srch_done   = srch_end && !r_sv;
    assign o_sts.clr_done    = r_clr[AddrW];
    assign o_sts.red_done    = r_rdn;
    assign o_sts.rd_done     = r_sdone;
    assign o_sts.reduced     = r_reduced;
    assign o_sts.load_status = (i_ctl.cmd == C_LD_RD) ?
        ((!r_rfound && r_rcnt >= CntW'(MaxRows)) ? ST_ROW_FULL :
         (!r_cfound && r_ccnt >= CntW'(MaxCols)) ? ST_COL_FULL : ST_OK) : r_lst;

    // Result word
    logic w_isrd;
    assign w_isrd = (r_op == OP_READ) && (r_lst == ST_OK);
    assign o_status     = (r_op == OP_CLEAR) ? ST_OK : r_lst;
    assign o_kept_rows  = r_kept;
    assign o_out_row    = (w_isrd && r_shit) ? r_orow : '0;
    assign o_out_col_id = (w_isrd && r_shit) ? r_ocid : '0;
    assign o_out_value  = (w_isrd && r_shit) ? r_oval : '0;
    assign o_done_res   = w_isrd && !r_shit;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= CntW'(MaxRows) && r_ccnt <= CntW'(MaxCols))
        else $error("id count overflow");
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= r_rcnt)
        else $error("kept rows exceed rows");
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fin && w_isrd) |-> r_sdone)
        else $error("read result without finished scan");
endmodule

// ===== verif/testbench.sv =====
// Testbench for the sparse row dominance filter: directed and random command words.
`timescale 1ns / 1ps

// One result word of the unit
typedef struct {
    logic [1:0]         status;
    logic [6:0]         kept;
    logic [6:0]         row;
    logic [15:0]        col;
    logic signed [31:0] value;
    logic               done;
} filt_word_t;

// Tracks the filter contents and holds the result words still owed by the unit
class filter_scoreboard;
    logic [15:0]        row_ids[srdf_pkg::MaxRows];
    logic [15:0]        col_ids[srdf_pkg::MaxCols];
    int                 n_rows, n_cols;
    logic signed [31:0] cells[srdf_pkg::MaxRows * srdf_pkg::MaxCols];
    bit                 dropped[srdf_pkg::MaxRows];
    int                 cur_row, cur_col, kept_num, kept_total;
    bit                 is_reduced;
    filt_word_t         owed[$];
    int                 errors;

    // Starts from the reset state of the unit
    function new();
        wipe();
    endfunction

    function void wipe();
        n_rows = 0;
        n_cols = 0;
        foreach (cells[i]) cells[i] = 0;
        foreach (dropped[i]) dropped[i] = 0;
        cur_row = 0;
        cur_col = 0;
        kept_num = 0;
        kept_total = 0;
        is_reduced = 0;
    endfunction

    function int row_le(int a, int b);
        for (int c = 0; c < n_cols; c++)
            if (cells[a * srdf_pkg::MaxCols + c] > cells[b * srdf_pkg::MaxCols + c])
                return 0;
        return 1;
    endfunction

    // Works out the result of one accepted command word
    function void note_word(logic [1:0] op, logic [15:0] rid, logic [15:0] cid,
                            logic signed [15:0] val);
        filt_word_t w;
        int r, c, idx;
        longint sum;
        w = '{status: srdf_pkg::ST_OK, kept: 0, row: 0, col: 0, value: 0, done: 0};
        case (op)
            srdf_pkg::OP_LOAD: begin
                if (is_reduced) begin
                    w.status = srdf_pkg::ST_ORDER;
                end else begin
                    r = -1;
                    c = -1;
                    for (int i = n_rows - 1; i >= 0; i--) if (row_ids[i] == rid) r = i;
                    for (int i = n_cols - 1; i >= 0; i--) if (col_ids[i] == cid) c = i;
                    if (r < 0 && n_rows >= srdf_pkg::MaxRows) begin
                        w.status = srdf_pkg::ST_ROW_FULL;
                    end else if (c < 0 && n_cols >= srdf_pkg::MaxCols) begin
                        w.status = srdf_pkg::ST_COL_FULL;
                    end else begin
                        if (r < 0) begin
                            r = n_rows;
                            row_ids[n_rows++] = rid;
                        end
                        if (c < 0) begin
                            c = n_cols;
                            col_ids[n_cols++] = cid;
                        end
                        idx = r * srdf_pkg::MaxCols + c;
                        sum = longint'(cells[idx]) + longint'(val);
                        if (sum > 64'sh7fff_ffff) sum = 64'sh7fff_ffff;
                        if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
                        cells[idx] = sum[31:0];
                    end
                end
            end
            srdf_pkg::OP_REDUCE: begin
                if (is_reduced) begin
                    w.status = srdf_pkg::ST_ORDER;
                end else begin
                    for (int a = 0; a < n_rows; a++) begin
                        if (!dropped[a])
                            for (int b = 0; b < n_rows; b++)
                                if (b != a && !dropped[b] && row_le(a, b)) dropped[b] = 1;
                    end
                    kept_total = 0;
                    for (int a = 0; a < n_rows; a++) if (!dropped[a]) kept_total++;
                    is_reduced = 1;
                    cur_row = 0;
                    cur_col = 0;
                    kept_num = 0;
                end
            end
            srdf_pkg::OP_READ: begin
                if (!is_reduced) begin
                    w.status = srdf_pkg::ST_ORDER;
                end else begin
                    w.done = 1;
                    // scan to the next nonzero cell of a kept row
                    while (w.done && cur_row < n_rows) begin
                        if (!dropped[cur_row]) begin
                            while (w.done && cur_col < n_cols) begin
                                idx = cur_row * srdf_pkg::MaxCols + cur_col;
                                cur_col++;
                                if (cells[idx] != 0) begin
                                    w.done = 0;
                                    w.row = 7'(kept_num + 1);
                                    w.col = col_ids[cur_col - 1];
                                    w.value = cells[idx];
                                end
                            end
                            if (w.done) kept_num++;
                        end
                        if (w.done) begin
                            cur_row++;
                            cur_col = 0;
                        end
                    end
                end
            end
            default: wipe();
        endcase
        w.kept = 7'(kept_total);
        owed.push_back(w);
    endfunction

    // Compares one result word with the oldest owed one
    function void check_word(filt_word_t got);
        filt_word_t exp;
        if (owed.size() == 0) begin
            $error("unexpected result word");
            errors++;
            return;
        end
        exp = owed.pop_front();
        if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
        end
        if (got.kept !== exp.kept) begin
            $error("kept_rows: expected %0d, got %0d", exp.kept, got.kept);
            errors++;
        end
        if (got.row !== exp.row) begin
            $error("out_row: expected %0d, got %0d", exp.row, got.row);
            errors++;
        end
        if (got.col !== exp.col) begin
            $error("out_col_id: expected %0d, got %0d", exp.col, got.col);
            errors++;
        end
        if (got.value !== exp.value) begin
            $error("out_value: expected %0d, got %0d", exp.value, got.value);
            errors++;
        end
        if (got.done !== exp.done) begin
            $error("done_res: expected %0d, got %0d", exp.done, got.done);
            errors++;
        end
    endfunction
endclass

module testbench;
    import srdf_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_operation;
    logic [15:0]        i_row_id;
    logic [15:0]        i_col_id;
    logic signed [15:0] i_value;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [6:0]         o_kept_rows;
    logic [6:0]         o_out_row;
    logic [15:0]        o_out_col_id;
    logic signed [31:0] o_out_value;
    logic               o_done_res;

    filter_scoreboard sb = new();
    int gap_pct;
    logic [15:0] row_pool[8];
    logic [15:0] col_pool[8];

    sparse_row_dominance_filter_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_word('{status: o_status, kept: o_kept_rows, row: o_out_row,
                            col: o_out_col_id, value: o_out_value, done: o_done_res});
    end

    // Sends one command word, with a random gap ahead of it
    task automatic issue(logic [1:0] op, logic [15:0] rid = 0, logic [15:0] cid = 0,
                         logic signed [15:0] val = 0);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start = 0;
        end
        @(negedge i_clk);
        start       = 1;
        i_operation = op;
        i_row_id    = rid;
        i_col_id    = cid;
        i_value     = val;
        do @(posedge i_clk); while (busy);
        sb.note_word(op, rid, cid, val);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 0;
        while (sb.owed.size() > 0) @(posedge i_clk);
    endtask

    // One load / reduce / read pass on small tables, with some broken ordering
    task automatic random_pass();
        int nloads;
        logic [15:0] vrand;
        foreach (row_pool[i]) row_pool[i] = 16'($urandom_range(16'hffff));
        foreach (col_pool[i]) col_pool[i] = 16'($urandom_range(16'hffff));
        if ($urandom_range(99) < 85)
            issue(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(99) < 10)
            issue(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom));
        nloads = $urandom_range(1, 16);
        repeat (nloads) begin
            vrand = ($urandom_range(99) < 25) ? 16'($urandom) : 16'($urandom_range(6) - 3);
            issue(OP_LOAD, row_pool[$urandom_range(7)], col_pool[$urandom_range(5)], vrand);
        end
        issue(OP_REDUCE, 16'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(99) < 10) issue(OP_REDUCE);
        if ($urandom_range(99) < 10) issue(OP_LOAD, row_pool[0], col_pool[0], 1);
        repeat (nloads + 2) issue(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        start       = 0;
        i_operation = OP_CLEAR;
        i_row_id    = 0;
        i_col_id    = 0;
        i_value     = 0;
        i_rst_n     = 0;
        gap_pct     = 30;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: ordering errors, extreme fields, equal rows, reads past the end
        issue(OP_READ);
        issue(OP_LOAD, 16'h0000, 16'h0000, 16'sh7fff);
        issue(OP_LOAD, 16'hffff, 16'hffff, -16'sh8000);
        issue(OP_LOAD, 16'h0000, 16'hffff, 16'sh0005);
        issue(OP_LOAD, 16'hffff, 16'h0000, 16'sh7fff);
        issue(OP_LOAD, 16'h5555, 16'h0000, 16'sh7fff);
        issue(OP_LOAD, 16'h5555, 16'hffff, -16'sh8000);
        issue(OP_LOAD, 16'h0000, 16'h0000, -16'sh0001);
        issue(OP_REDUCE);
        issue(OP_REDUCE);
        issue(OP_LOAD, 16'haaaa, 16'haaaa, 16'sh0001);
        repeat (6) issue(OP_READ);
        issue(OP_CLEAR);
        issue(OP_REDUCE);
        issue(OP_READ);
        issue(OP_CLEAR);

        // Row table full
        for (int i = 0; i < MaxRows; i++) issue(OP_LOAD, 16'(i * 3 + 1), 16'h0007, 16'(i - 20));
        issue(OP_LOAD, 16'h9999, 16'h0007, 16'sh0001);
        issue(OP_LOAD, 16'h9999, 16'h1234, 16'sh0001);
        issue(OP_LOAD, 16'h0004, 16'h1234, 16'sh0002);
        issue(OP_REDUCE);
        repeat (4) issue(OP_READ);
        issue(OP_CLEAR);

        // Column table full
        for (int i = 0; i < MaxCols; i++) issue(OP_LOAD, 16'h0042, 16'(i * 5 + 2), 16'(i + 1));
        issue(OP_LOAD, 16'h0042, 16'hbeef, 16'sh0001);
        issue(OP_LOAD, 16'h0043, 16'hbeef, 16'sh0001);
        issue(OP_LOAD, 16'h0043, 16'h0002, 16'sh0001);
        issue(OP_REDUCE);
        repeat (MaxCols + 4) issue(OP_READ);

        // Random passes; the sender pauses for an empty pipe once per phase
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 30 : (ph == 1) ? 46 : 0;
            repeat (14) random_pass();
            drain();
        end

        // Long accumulation in two cells, both signs
        gap_pct = 0;
        issue(OP_CLEAR);
        repeat (60) issue(OP_LOAD, 16'h0001, 16'h0001, 16'sh7fff);
        issue(OP_LOAD, 16'h0001, 16'h0001, -16'sh0001);
        repeat (60) issue(OP_LOAD, 16'h0001, 16'h0002, -16'sh8000);
        issue(OP_REDUCE);
        repeat (3) issue(OP_READ);

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule
